// ----- hdl/lsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Line segment clipper package
// Shared types and constants for the Liang-Barsky clipping pipeline.
// ----------------------------------------------------------------------------
package lsc_pkg;

   localparam int CoordBits = 16;
   localparam int FracBits  = 16;
   // magnitude bits of a boundary distance or direction
   localparam int MagBits   = CoordBits + 1;
   // ratio magnitude: Q1.FRAC
   localparam int RatBits   = FracBits + 1;

   localparam logic [2:0] CSR_C1X = 3'd0;
   localparam logic [2:0] CSR_C1Y = 3'd1;
   localparam logic [2:0] CSR_C2X = 3'd2;
   localparam logic [2:0] CSR_C2Y = 3'd3;
   localparam logic [2:0] CSR_C3X = 3'd4;
   localparam logic [2:0] CSR_C3Y = 3'd5;
   localparam logic [2:0] CSR_C4X = 3'd6;
   localparam logic [2:0] CSR_C4Y = 3'd7;

   typedef struct packed {
      logic signed [CoordBits-1:0] start_x;
      logic signed [CoordBits-1:0] start_y;
      logic signed [CoordBits-1:0] end_x;
      logic signed [CoordBits-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic                        visible;
      logic signed [CoordBits-1:0] clip_start_x;
      logic signed [CoordBits-1:0] clip_start_y;
      logic signed [CoordBits-1:0] clip_end_x;
      logic signed [CoordBits-1:0] clip_end_y;
   } rsp_type;

endpackage

// ----- hdl/lsc_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step for each of four lanes; hands the partial
// quotient, remainder and carried item to the next cell every cycle.
// ----------------------------------------------------------------------------
module lsc_div_cell #(
   parameter int MAG_BITS = 17,
   parameter int Q_BITS   = 17,
   parameter int PASS_BITS = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [4*MAG_BITS-1:0] in_div,
   input  logic [4*(MAG_BITS+1)-1:0] in_rem,
   input  logic [4*Q_BITS-1:0]   in_quo,
   input  logic [PASS_BITS-1:0]  in_pass,
   output logic                  out_valid,
   output logic [4*MAG_BITS-1:0] out_div,
   output logic [4*(MAG_BITS+1)-1:0] out_rem,
   output logic [4*Q_BITS-1:0]   out_quo,
   output logic [PASS_BITS-1:0]  out_pass
);
   logic                  valid_ff;
   logic [4*MAG_BITS-1:0] div_ff;
   logic [4*(MAG_BITS+1)-1:0] rem_ff, rem_in;
   logic [4*Q_BITS-1:0]   quo_ff, quo_in;
   logic [PASS_BITS-1:0]  pass_ff;

   // shift, compare and subtract in every lane
   always_comb begin
      logic [MAG_BITS+1:0] sh;
      logic [MAG_BITS+1:0] dv;
      for (int i = 0; i < 4; i++) begin
         sh = {in_rem[i*(MAG_BITS+1) +: MAG_BITS+1], 1'b0};
         dv = {2'b00, in_div[i*MAG_BITS +: MAG_BITS]};
         if (sh >= dv) begin
            rem_in[i*(MAG_BITS+1) +: MAG_BITS+1] = (MAG_BITS+1)'(sh - dv);
            quo_in[i*Q_BITS +: Q_BITS] = {in_quo[i*Q_BITS +: Q_BITS-1], 1'b1};
         end else begin
            rem_in[i*(MAG_BITS+1) +: MAG_BITS+1] = sh[MAG_BITS:0];
            quo_in[i*Q_BITS +: Q_BITS] = {in_quo[i*Q_BITS +: Q_BITS-1], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      div_ff  <= in_div;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      pass_ff <= in_pass;
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_pass  = pass_ff;
endmodule

// ----- hdl/lsc_adv_unit.sv -----
// ----------------------------------------------------------------------------
// Endpoint advance unit
// Computes trunc(a + t*d) for one coordinate in two registered stages; gives in_keep when in_use is low.
// ----------------------------------------------------------------------------
module lsc_adv_unit #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic signed [COORD_BITS-1:0] in_a,
   input  logic signed [COORD_BITS:0]   in_d,
   input  logic [FRAC_BITS:0]           in_t,
   input  logic                         in_use,
   input  logic signed [COORD_BITS-1:0] in_keep,
   output logic signed [COORD_BITS-1:0] out_res
);
   localparam int MB = COORD_BITS + 1;
   localparam int PB = MB + FRAC_BITS + 1;

   logic [PB-1:0]               prod_ff, prod_in;
   logic signed [COORD_BITS-1:0] a_ff, keep_ff, res_ff, res_in;
   logic                        neg_ff, use_ff;

   // multiply the direction magnitude by t
   always_comb begin
      logic [MB-1:0] da;
      da = in_d[COORD_BITS] ? MB'(-in_d) : MB'(in_d);
      prod_in = PB'(da) * PB'(in_t);
   end

   // add integer part and truncate toward zero
   always_comb begin
      logic signed [PB+1:0] ip, lo, hi, ax;
      logic frac;
      ip   = (PB+2)'(prod_ff >> FRAC_BITS);
      frac = prod_ff[FRAC_BITS-1:0] != '0;
      ax   = (PB+2)'(a_ff);
      if (!neg_ff) begin
         lo = ax + ip;
         hi = lo + 1;
      end else begin
         hi = ax - ip;
         lo = hi - 1;
      end
      if (!frac) res_in = neg_ff ? COORD_BITS'(hi) : COORD_BITS'(lo);
      else       res_in = (lo >= 0) ? COORD_BITS'(lo) : COORD_BITS'(hi);
      if (!use_ff) res_in = keep_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= in_a;
      neg_ff  <= in_d[COORD_BITS];
      use_ff  <= in_use;
      keep_ff <= in_keep;
      res_ff  <= res_in;
   end

   assign out_res = res_ff;
endmodule

// ----- hdl/line_segment_clipper_unit.sv -----
// ----------------------------------------------------------------------------
// Line segment clipper
// Liang-Barsky clipping of segments against a window set by four corners.
// ----------------------------------------------------------------------------
// Usage: write corner registers through the csr_ channel (index 0..7 =
// corner1_x .. corner4_y) while no transaction is in flight; csr_ready is
// always high and every index names a corner. Pulse start with a segment on
// req_data whenever busy is low; busy never rises, so one segment enters per
// cycle. Each transaction yields one result: rsp_valid is high for exactly
// one cycle with rsp_data. Segments pass through setup, a chain of FRAC_BITS
// divider cells (one quotient bit per cell for all four boundary ratios in
// parallel), a boundary test and a two-stage endpoint multiply. Throughput
// is one segment per cycle. The receiver cannot stall the output. Reset
// clears all in-flight valids and the window to zero.
// ----------------------------------------------------------------------------
module line_segment_clipper_unit #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lsc_pkg::req_type req_data,
   output logic             rsp_valid,
   output lsc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [COORD_BITS-1:0] csr_data
);
   localparam int CB = COORD_BITS;
   localparam int MB = CB + 1;
   localparam int QB = FRAC_BITS + 1;
   localparam int NC = FRAC_BITS + 1;
   // carried: sign flags (4), p-zero (4), q>=0 (4), sat (4), x1,y1,dx,dy
   localparam int PASS = 16 + 2*CB + 2*(CB+1);

   logic signed [CB-1:0] corner_ff [8];

   // configuration writes
   assign csr_ready = 1'b1;
   assign busy      = 1'b0;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) corner_ff[i] <= '0;
      end else if (csr_valid) begin
         corner_ff[csr_index] <= csr_data;
      end
   end

   // window bounds
   logic signed [CB-1:0] minx, maxx, miny, maxy;
   always_comb begin
      minx = corner_ff[lsc_pkg::CSR_C1X]; maxx = minx;
      miny = corner_ff[lsc_pkg::CSR_C1Y]; maxy = miny;
      for (int i = 1; i < 4; i++) begin
         if (corner_ff[2*i] < minx) minx = corner_ff[2*i];
         if (corner_ff[2*i] > maxx) maxx = corner_ff[2*i];
         if (corner_ff[2*i+1] < miny) miny = corner_ff[2*i+1];
         if (corner_ff[2*i+1] > maxy) maxy = corner_ff[2*i+1];
      end
   end

   // setup stage: boundary p and q per test
   logic                  s0_valid_ff;
   logic signed [CB-1:0]  s0_x1_ff, s0_y1_ff;
   logic signed [CB:0]    s0_dx_ff, s0_dy_ff;
   logic signed [CB:0]    s0_q_ff [4];
   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else       s0_valid_ff <= start;
      s0_x1_ff <= CB'(req_data.start_x);
      s0_y1_ff <= CB'(req_data.start_y);
      s0_dx_ff <= (CB+1)'(req_data.end_x) - (CB+1)'(req_data.start_x);
      s0_dy_ff <= (CB+1)'(req_data.end_y) - (CB+1)'(req_data.start_y);
      s0_q_ff[0] <= (CB+1)'(req_data.start_x) - (CB+1)'(minx);
      s0_q_ff[1] <= (CB+1)'(maxx) - (CB+1)'(req_data.start_x);
      s0_q_ff[2] <= (CB+1)'(req_data.start_y) - (CB+1)'(miny);
      s0_q_ff[3] <= (CB+1)'(maxy) - (CB+1)'(req_data.start_y);
   end

   // chain input: magnitudes, first quotient bit, saturation
   logic [4*MB-1:0]     c_div [NC+1];
   logic [4*(MB+1)-1:0] c_rem [NC+1];
   logic [4*QB-1:0]     c_quo [NC+1];
   logic [PASS-1:0]     c_pass [NC+1];
   logic                c_valid [NC+1];
   always_comb begin
      logic signed [CB:0] p;
      logic [MB-1:0] pa, qa;
      logic [3:0] pneg, pz, qnn, sat;
      for (int i = 0; i < 4; i++) begin
         p = (i < 2) ? ((i == 0) ? -s0_dx_ff : s0_dx_ff)
                     : ((i == 2) ? -s0_dy_ff : s0_dy_ff);
         pa = p[CB] ? MB'(-p) : MB'(p);
         qa = s0_q_ff[i][CB] ? MB'(-s0_q_ff[i]) : MB'(s0_q_ff[i]);
         pneg[i] = p[CB];
         pz[i]   = (p == '0);
         qnn[i]  = !s0_q_ff[i][CB];
         sat[i]  = ({1'b0, qa} >= {pa, 1'b0});
         c_div[0][i*MB +: MB] = pa;
         c_rem[0][i*(MB+1) +: MB+1] = (qa >= pa) ? (MB+1)'(qa - pa) : (MB+1)'(qa);
         // the leading quotient bit is taken here; cells make the rest
         c_quo[0][i*QB +: QB] = QB'(qa >= pa);
      end
      c_pass[0] = {pneg, pz, qnn, sat, s0_x1_ff, s0_y1_ff, s0_dx_ff, s0_dy_ff};
      c_valid[0] = s0_valid_ff;
   end

   // one cell per fraction bit
   for (genvar g = 0; g < NC - 1; g++) begin : g_cell
      lsc_div_cell #(.MAG_BITS(MB), .Q_BITS(QB), .PASS_BITS(PASS)) u_cell (
         .clock(clock), .reset(reset),
         .in_valid(c_valid[g]), .in_div(c_div[g]), .in_rem(c_rem[g]),
         .in_quo(c_quo[g]), .in_pass(c_pass[g]),
         .out_valid(c_valid[g+1]), .out_div(c_div[g+1]), .out_rem(c_rem[g+1]),
         .out_quo(c_quo[g+1]), .out_pass(c_pass[g+1])
      );
   end
   assign c_valid[NC] = c_valid[NC-1];
   assign c_div[NC]   = c_div[NC-1];
   assign c_rem[NC]   = c_rem[NC-1];
   assign c_quo[NC]   = c_quo[NC-1];
   assign c_pass[NC]  = c_pass[NC-1];

   // boundary tests in order, on finished ratios
   logic [3:0] f_pneg, f_pz, f_qnn, f_sat;
   logic signed [CB-1:0] f_x1, f_y1;
   logic signed [CB:0]   f_dx, f_dy;
   assign {f_pneg, f_pz, f_qnn, f_sat, f_x1, f_y1, f_dx, f_dy} = c_pass[NC];

   logic t_ok;
   logic [QB-1:0] t1_v, t2_v;
   always_comb begin
      logic signed [QB+1:0] r, t1, t2;
      logic [QB-1:0] m;
      logic neg, rz;
      t1 = '0;
      t2 = (QB+2)'(1) <<< FRAC_BITS;
      t_ok = 1'b1;
      for (int i = 0; i < 4; i++) begin
         m  = c_quo[NC][i*QB +: QB];
         rz = c_rem[NC][i*(MB+1) +: MB+1] != '0;
         neg = !f_qnn[i] ? 1'b1 : 1'b0;
         // q is zero: not negative
         if (f_sat[i]) m = '1;
         if (neg ^ f_pneg[i]) begin
            if (!f_sat[i] && rz && m != '1) m = m + 1'b1;
            r = -(QB+2)'(m);
         end else begin
            r = (QB+2)'(m);
         end
         if (t_ok) begin
            if (f_pz[i]) begin
               t_ok = f_qnn[i];
            end else if (f_pneg[i]) begin
               if (r > t2) t_ok = 1'b0;
               else if (r > t1) t1 = r;
            end else begin
               if (r < t1) t_ok = 1'b0;
               else if (r < t2) t2 = r;
            end
         end
      end
      t1_v = QB'(t1);
      t2_v = QB'(t2);
   end

   logic                 ts_valid_ff, ts_ok_ff;
   logic [QB-1:0]        ts_t1_ff, ts_t2_ff;
   logic signed [CB-1:0] ts_x1_ff, ts_y1_ff, ts_x2_ff, ts_y2_ff;
   logic signed [CB:0]   ts_dx_ff, ts_dy_ff;
   always_ff @(posedge clock) begin
      if (reset) ts_valid_ff <= 1'b0;
      else       ts_valid_ff <= c_valid[NC];
      ts_ok_ff <= t_ok;
      ts_t1_ff <= t1_v;
      ts_t2_ff <= t2_v;
      ts_x1_ff <= f_x1;
      ts_y1_ff <= f_y1;
      ts_dx_ff <= f_dx;
      ts_dy_ff <= f_dy;
      ts_x2_ff <= CB'(f_x1 + f_dx);
      ts_y2_ff <= CB'(f_y1 + f_dy);
   end

   // endpoint advance
   logic use1, use2;
   assign use1 = ts_t1_ff != '0;
   assign use2 = !ts_t2_ff[FRAC_BITS];
   logic signed [CB-1:0] nx1, ny1, nx2, ny2;
   lsc_adv_unit #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_ax1 (
      .clock(clock), .in_a(ts_x1_ff), .in_d(ts_dx_ff), .in_t(ts_t1_ff),
      .in_use(use1), .in_keep(ts_x1_ff), .out_res(nx1));
   lsc_adv_unit #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_ay1 (
      .clock(clock), .in_a(ts_y1_ff), .in_d(ts_dy_ff), .in_t(ts_t1_ff),
      .in_use(use1), .in_keep(ts_y1_ff), .out_res(ny1));
   lsc_adv_unit #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_ax2 (
      .clock(clock), .in_a(ts_x1_ff), .in_d(ts_dx_ff), .in_t(ts_t2_ff),
      .in_use(use2), .in_keep(ts_x2_ff), .out_res(nx2));
   lsc_adv_unit #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_ay2 (
      .clock(clock), .in_a(ts_y1_ff), .in_d(ts_dy_ff), .in_t(ts_t2_ff),
      .in_use(use2), .in_keep(ts_y2_ff), .out_res(ny2));

   // match the two advance stages
   logic [1:0] v_ff, ok_ff;
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[0], ts_valid_ff};
      ok_ff <= {ok_ff[0], ts_ok_ff};
   end

   assign rsp_valid = v_ff[1];
   always_comb begin
      rsp_data.visible      = ok_ff[1];
      rsp_data.clip_start_x = ok_ff[1] ? nx1 : '0;
      rsp_data.clip_start_y = ok_ff[1] ? ny1 : '0;
      rsp_data.clip_end_x   = ok_ff[1] ? nx2 : '0;
      rsp_data.clip_end_y   = ok_ff[1] ? ny2 : '0;
   end
endmodule

// ----- bench/line_segment_clipper_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line segment clipper checker
// Watches the window register, segment and result channels. Keeps its own
// copy of the window corners, predicts each clipped segment with a Q1.16
// Liang-Barsky model and compares every result in order.
// ----------------------------------------------------------------------------
module line_segment_clipper_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  lsc_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  lsc_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [lsc_pkg::CoordBits-1:0] csr_data,
   output int                            fail_count,
   output int                            pending
);

   localparam longint TOne = longint'(1) <<< lsc_pkg::FracBits;
   localparam longint RMax = (longint'(2) <<< lsc_pkg::FracBits) - 1;
   localparam longint FMask = TOne - 1;

   logic signed [lsc_pkg::CoordBits-1:0] corner_reg [8];
   lsc_pkg::rsp_type clipped_q[$];

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // floor(q/p) in Q1.16, magnitude saturated
   function automatic longint boundary_ratio(longint p, longint q);
      longint pa, qa, m, rem;
      bit neg;
      pa = mag(p);
      qa = mag(q);
      neg = (q != 0) && ((q < 0) != (p < 0));
      if (qa >= 2 * pa) return neg ? -RMax : RMax;
      m = (qa >= pa) ? 1 : 0;
      rem = qa - m * pa;
      for (int i = 0; i < lsc_pkg::FracBits; i++) begin
         rem = rem <<< 1;
         m = m <<< 1;
         if (rem >= pa) begin
            rem -= pa;
            m |= 1;
         end
      end
      if (!neg) return m;
      if (rem != 0) m += 1;
      if (m > RMax) m = RMax;
      return -m;
   endfunction

   // narrow t_in / t_out against one boundary; 0 means rejected
   function automatic bit boundary_pass(longint p, longint q,
                                        inout longint t_in, inout longint t_out);
      longint r;
      if (p == 0) return q >= 0;
      r = boundary_ratio(p, q);
      if (p < 0) begin
         if (r > t_out) return 0;
         if (r > t_in) t_in = r;
      end else begin
         if (r < t_in) return 0;
         if (r < t_out) t_out = r;
      end
      return 1;
   endfunction

   // a + t*d, truncated toward zero
   function automatic longint move_point(longint a, longint d, longint t);
      longint da, ti, tf, m, ip, lo, hi;
      bit frac;
      da = mag(d);
      ti = t >>> lsc_pkg::FracBits;
      tf = t & FMask;
      m = tf * da;
      ip = (m >>> lsc_pkg::FracBits) + ti * da;
      frac = (m & FMask) != 0;
      if (d >= 0) begin
         lo = a + ip;
         hi = lo + 1;
      end else begin
         hi = a - ip;
         lo = hi - 1;
      end
      if (!frac) return (d >= 0) ? lo : hi;
      return (lo >= 0) ? lo : hi;
   endfunction

   function automatic lsc_pkg::rsp_type clip_segment(lsc_pkg::req_type s);
      longint x1, y1, x2, y2, dx, dy, t_in, t_out;
      longint min_x, max_x, min_y, max_y, cx, cy;
      longint nx1, ny1, nx2, ny2;
      bit ok;
      lsc_pkg::rsp_type r;
      x1 = s.start_x; y1 = s.start_y; x2 = s.end_x; y2 = s.end_y;
      dx = x2 - x1; dy = y2 - y1;
      t_in = 0; t_out = TOne;
      min_x = corner_reg[0]; max_x = min_x;
      min_y = corner_reg[1]; max_y = min_y;
      for (int i = 1; i < 4; i++) begin
         cx = corner_reg[2*i];
         cy = corner_reg[2*i+1];
         if (cx < min_x) min_x = cx;
         if (cx > max_x) max_x = cx;
         if (cy < min_y) min_y = cy;
         if (cy > max_y) max_y = cy;
      end
      ok = boundary_pass(-dx, x1 - min_x, t_in, t_out)
        && boundary_pass(dx, max_x - x1, t_in, t_out)
        && boundary_pass(-dy, y1 - min_y, t_in, t_out)
        && boundary_pass(dy, max_y - y1, t_in, t_out);
      r = '0;
      if (!ok) return r;
      nx1 = x1; ny1 = y1; nx2 = x2; ny2 = y2;
      if (t_out < TOne) begin
         nx2 = move_point(x1, dx, t_out);
         ny2 = move_point(y1, dy, t_out);
      end
      if (t_in > 0) begin
         nx1 = move_point(x1, dx, t_in);
         ny1 = move_point(y1, dy, t_in);
      end
      r.visible = 1'b1;
      r.clip_start_x = nx1[lsc_pkg::CoordBits-1:0];
      r.clip_start_y = ny1[lsc_pkg::CoordBits-1:0];
      r.clip_end_x = nx2[lsc_pkg::CoordBits-1:0];
      r.clip_end_y = ny2[lsc_pkg::CoordBits-1:0];
      return r;
   endfunction

   assign pending = clipped_q.size();

   // track the window, predict each accepted segment, compare each result
   always @(posedge clock) begin
      lsc_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < 8; i++) corner_reg[i] <= '0;
         fail_count <= 0;
         clipped_q.delete();
      end else begin
         if (csr_valid && csr_ready) corner_reg[csr_index] <= csr_data;
         if (start && !busy) clipped_q.push_back(clip_segment(req_data));
         if (rsp_valid) begin
            if (clipped_q.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: unexpected result %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = clipped_q.pop_front();
               if (rsp_data !== want) begin
                  if (fail_count < 10)
                     $display({"ERROR: clip mismatch exp vis=%0d (%0d,%0d)-(%0d,%0d)",
                               " got vis=%0d (%0d,%0d)-(%0d,%0d)"},
                        want.visible, want.clip_start_x, want.clip_start_y,
                        want.clip_end_x, want.clip_end_y,
                        rsp_data.visible, rsp_data.clip_start_x, rsp_data.clip_start_y,
                        rsp_data.clip_end_x, rsp_data.clip_end_y);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line segment clipper testbench
// Programs a series of clip windows (point, regular, line, full range, random) and
// feeds directed and random segments with varying sender gaps; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

   localparam int WatchLimit = 5000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   lsc_pkg::req_type req_data;
   logic rsp_valid;
   lsc_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_index;
   logic [lsc_pkg::CoordBits-1:0] csr_data;
   int fail_count;
   int pending;
   int gap_pct;
   int quiet_cycles;

   line_segment_clipper_unit DUT (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   line_segment_clipper_checker checker_i (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data, .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("line_segment_clipper_unit verification failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 16'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_window(input int x1, y1, x2, y2, x3, y3, x4, y4);
      write_reg(lsc_pkg::CSR_C1X, x1); write_reg(lsc_pkg::CSR_C1Y, y1);
      write_reg(lsc_pkg::CSR_C2X, x2); write_reg(lsc_pkg::CSR_C2Y, y2);
      write_reg(lsc_pkg::CSR_C3X, x3); write_reg(lsc_pkg::CSR_C3Y, y3);
      write_reg(lsc_pkg::CSR_C4X, x4); write_reg(lsc_pkg::CSR_C4Y, y4);
   endtask

   // hold start until the segment is taken, with random idle cycles ahead
   task automatic send_segment(input int sx, sy, ex, ey);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{16'(sx), 16'(sy), 16'(ex), 16'(ey)};
      do @(posedge clock); while (busy);
   endtask

   function automatic logic signed [15:0] near(int centre);
      int v;
      v = centre + $urandom_range(400) - 200;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   task automatic random_segments(input int count, input int cx, input int cy);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            send_segment($urandom, $urandom, $urandom, $urandom);
         else if ($urandom_range(5) == 0)
            // axis-aligned segment
            begin
               logic signed [15:0] a;
               a = near(cx);
               send_segment(a, near(cy), a, near(cy));
            end
         else
            send_segment(near(cx), near(cy), near(cx), near(cy));
      end
   endtask

   // drain all results before the window changes
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      gap_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // point window at the origin left by reset
      send_segment(-10, 0, 10, 0);
      send_segment(0, 0, 0, 0);
      send_segment(1, 1, 1, 1);
      random_segments(40, 0, 0);
      drain();

      // regular window, directed cases
      set_window(-100, -50, 100, -50, 100, 50, -100, 50);
      send_segment(-10, -10, 10, 10);       // fully inside
      send_segment(-300, 0, -200, 0);       // left of window
      send_segment(200, 0, 300, 5);         // right of window
      send_segment(0, -300, 5, -200);       // below
      send_segment(0, 200, 5, 300);         // above
      send_segment(-300, -7, 300, 9);       // crosses both x bounds
      send_segment(300, 80, -300, -80);     // crosses in reverse
      send_segment(0, -500, 0, 500);        // vertical, inside x range
      send_segment(150, -500, 150, 500);    // vertical, outside x range
      send_segment(-500, 0, 500, 0);        // horizontal
      send_segment(-500, 60, 500, 60);      // horizontal, outside
      send_segment(5, 5, 5, 5);             // point inside
      send_segment(500, 5, 500, 5);         // point outside
      send_segment(-100, -50, 100, 50);     // corner to corner
      send_segment(-32768, -32768, 32767, 32767);
      send_segment(32767, -32768, -32768, 32767);
      send_segment(-32768, 0, 32767, 1);
      send_segment(-150, 0, 0, 150);        // clips a corner region
      send_segment(-200, -100, 200, 101);
      drain();

      gap_pct = 75;
      random_segments(80, 0, 0);
      drain();

      // full range window
      set_window(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      gap_pct = 0;
      send_segment(-32768, -32768, 32767, 32767);
      send_segment(32767, 32767, -32768, -32768);
      random_segments(80, 0, 0);
      drain();

      // vertical line window
      set_window(20, -40, 20, 70, 20, 5, 20, -40);
      gap_pct = 75;
      random_segments(70, 20, 0);
      drain();

      // random windows
      for (int w = 0; w < 4; w++) begin
         int cx, cy;
         cx = $signed(16'($urandom));
         cy = $signed(16'($urandom));
         set_window(near(cx), near(cy), near(cx), near(cy),
                    near(cx), near(cy), near(cx), near(cy));
         gap_pct = (w % 2 == 0) ? 32 : 75;
         random_segments(60, cx, cy);
         drain();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("line_segment_clipper_unit verification clean");
      else
         $display("line_segment_clipper_unit verification failed");
      $finish;
   end

endmodule
